[rtl/hrk_pkg.sv]
// Shared types, constants and lookup functions for the HID report to key event block.
package hrk_pkg;

    localparam int KEY_W         = 7;
    localparam int USAGE_W       = 8;
    localparam int MOD_IN_W      = 8;
    localparam int MOD_COUNT     = 4;
    localparam int MOD_IDX_W     = 2;
    localparam int USAGE_COUNT   = 6;
    localparam int USAGE_IDX_W   = 3;
    localparam int DEF_KEY_SLOTS = 6;
    localparam int QUEUE_DEPTH   = 2;

    // Event kinds on the output word
    localparam logic EVT_KEY  = 1'b0;
    localparam logic EVT_SYNC = 1'b1;

    typedef logic [USAGE_COUNT-1:0][KEY_W-1:0] t_keys;

    // One classified report: low modifier bits and mapped key codes
    typedef struct packed {
        logic [MOD_COUNT-1:0] mods;
        t_keys                keys;
    } t_report;

    // Head of the report queue as seen by the back end
    typedef struct packed {
        logic    valid;
        t_report rpt;
    } t_q_head;

    // Map a HID usage to an input key code; unlisted usages give zero
    function automatic logic [KEY_W-1:0] map_usage(input logic [USAGE_W-1:0] usage);
        logic [KEY_W-1:0] code;
        code = '0;
        case (usage)
            8'h1E: code = 7'd2;    8'h1F: code = 7'd3;    8'h20: code = 7'd4;
            8'h21: code = 7'd5;    8'h22: code = 7'd6;    8'h23: code = 7'd7;
            8'h24: code = 7'd8;    8'h25: code = 7'd9;    8'h26: code = 7'd10;
            8'h27: code = 7'd11;
            8'h14: code = 7'd16;   8'h1A: code = 7'd17;   8'h08: code = 7'd18;
            8'h15: code = 7'd19;   8'h17: code = 7'd20;   8'h1C: code = 7'd21;
            8'h18: code = 7'd22;   8'h0C: code = 7'd23;   8'h12: code = 7'd24;
            8'h13: code = 7'd25;
            8'h04: code = 7'd30;   8'h16: code = 7'd31;   8'h07: code = 7'd32;
            8'h09: code = 7'd33;   8'h0A: code = 7'd34;   8'h0B: code = 7'd35;
            8'h0D: code = 7'd36;   8'h0E: code = 7'd37;   8'h0F: code = 7'd38;
            8'h1D: code = 7'd44;   8'h1B: code = 7'd45;   8'h06: code = 7'd46;
            8'h19: code = 7'd47;   8'h05: code = 7'd48;   8'h11: code = 7'd49;
            8'h10: code = 7'd50;
            8'h28: code = 7'd28;   8'h29: code = 7'd1;    8'h2A: code = 7'd14;
            8'h2B: code = 7'd15;   8'h2C: code = 7'd57;
            8'h36: code = 7'd51;   8'h37: code = 7'd52;
            8'h50: code = 7'd105;  8'h52: code = 7'd103;  8'h51: code = 7'd108;
            8'h4F: code = 7'd106;
            8'h3A: code = 7'd59;   8'h3B: code = 7'd60;   8'h3C: code = 7'd61;
            8'h3D: code = 7'd62;   8'h3E: code = 7'd63;   8'h3F: code = 7'd64;
            8'h40: code = 7'd65;   8'h41: code = 7'd66;   8'h42: code = 7'd67;
            8'h43: code = 7'd68;   8'h44: code = 7'd87;   8'h45: code = 7'd88;
            8'h4A: code = 7'd102;  8'h4B: code = 7'd104;  8'h4E: code = 7'd109;
            8'h4D: code = 7'd107;
            default: code = '0;
        endcase
        return code;
    endfunction

    // Key code of each modifier bit: ctrl, shift, alt, meta
    function automatic logic [KEY_W-1:0] modifier_key(input logic [MOD_IDX_W-1:0] idx);
        logic [KEY_W-1:0] code;
        code = '0;
        case (idx)
            2'd0:    code = 7'd29;
            2'd1:    code = 7'd42;
            2'd2:    code = 7'd56;
            default: code = 7'd125;
        endcase
        return code;
    endfunction

endpackage

[rtl/hrk_channels.sv]
// Valid/ready channel interfaces for report words and key event words.
interface hrk_rpt_if;
    logic                          valid;
    logic                          ready;
    logic [hrk_pkg::MOD_IN_W-1:0]  modifiers;
    logic [hrk_pkg::USAGE_W-1:0]   usage_0;
    logic [hrk_pkg::USAGE_W-1:0]   usage_1;
    logic [hrk_pkg::USAGE_W-1:0]   usage_2;
    logic [hrk_pkg::USAGE_W-1:0]   usage_3;
    logic [hrk_pkg::USAGE_W-1:0]   usage_4;
    logic [hrk_pkg::USAGE_W-1:0]   usage_5;

    modport source (output valid, modifiers, usage_0, usage_1, usage_2, usage_3, usage_4,
                    usage_5, input ready);
    modport sink   (input valid, modifiers, usage_0, usage_1, usage_2, usage_3, usage_4,
                    usage_5, output ready);
endinterface

interface hrk_evt_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [hrk_pkg::KEY_W-1:0]   key_code;
    logic                        pressed;
    logic                        last;

    modport source (output valid, event_kind, key_code, pressed, last, input ready);
    modport sink   (input valid, event_kind, key_code, pressed, last, output ready);
endinterface

[rtl/hrk_front.sv]
// Front end: accepts report words, maps usages to key codes and queues them.
module hrk_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hrk_rpt_if.sink          i_rpt,
    input  logic             i_pop,
    output hrk_pkg::t_q_head o_head
);

    localparam int PTR_W = (hrk_pkg::QUEUE_DEPTH > 1) ? $clog2(hrk_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hrk_pkg::QUEUE_DEPTH + 1);

    hrk_pkg::t_report r_mem [hrk_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    hrk_pkg::t_report rpt;
    logic             push;

    // Classify the incoming word
    always_comb begin
        rpt.mods    = i_rpt.modifiers[hrk_pkg::MOD_COUNT-1:0];
        rpt.keys[0] = hrk_pkg::map_usage(i_rpt.usage_0);
        rpt.keys[1] = hrk_pkg::map_usage(i_rpt.usage_1);
        rpt.keys[2] = hrk_pkg::map_usage(i_rpt.usage_2);
        rpt.keys[3] = hrk_pkg::map_usage(i_rpt.usage_3);
        rpt.keys[4] = hrk_pkg::map_usage(i_rpt.usage_4);
        rpt.keys[5] = hrk_pkg::map_usage(i_rpt.usage_5);
    end

    assign i_rpt.ready = (r_cnt != CNT_W'(hrk_pkg::QUEUE_DEPTH));
    assign push        = i_rpt.valid && i_rpt.ready;

    // Advance queue pointers
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(hrk_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(hrk_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the classified report
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= rpt;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.rpt   = r_mem[r_rd];

endmodule

[rtl/hrk_back.sv]
// Back end: holds key slots and modifier state, emits at most one event per cycle.
module hrk_back #(
    parameter int KEY_SLOTS = hrk_pkg::DEF_KEY_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrk_pkg::t_q_head i_head,
    output logic             o_pop,
    hrk_evt_if.source        o_evt
);

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int KW     = hrk_pkg::KEY_W;
    localparam int UC     = hrk_pkg::USAGE_COUNT;
    localparam int MC     = hrk_pkg::MOD_COUNT;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          r_state, n_state;
    logic [KEY_SLOTS-1:0][KW-1:0]  r_slots, n_slots;
    logic [MC-1:0]                 r_mods, n_mods;
    logic [MC-1:0]                 r_mod_mask, n_mod_mask;
    logic [KEY_SLOTS-1:0]          r_rel_mask, n_rel_mask;
    logic [UC-1:0]                 r_prs_mask, n_prs_mask;
    hrk_pkg::t_keys                r_keys, n_keys;
    logic                          r_any, n_any;
    logic                          r_out_valid, n_out_valid;
    logic                          r_kind, n_kind;
    logic [KW-1:0]                 r_code, n_code;
    logic                          r_pressed, n_pressed;
    logic                          r_last, n_last;

    logic [KEY_SLOTS-1:0]          ld_rel;
    logic [UC-1:0]                 ld_prs;
    logic [hrk_pkg::MOD_IDX_W-1:0] mod_idx;
    logic [SLOT_W-1:0]             rel_idx;
    logic [hrk_pkg::USAGE_IDX_W-1:0] prs_idx;
    logic [SLOT_W-1:0]             free_idx;
    logic                          free_any;
    logic                          can_emit;

    // Classify slots and keys against the new report
    always_comb begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
            ld_rel[s] = (r_slots[s] != '0);
            for (int j = 0; j < UC; j++) begin
                if (i_head.rpt.keys[j] == r_slots[s]) begin
                    ld_rel[s] = 1'b0;
                end
            end
        end
        for (int i = 0; i < UC; i++) begin
            ld_prs[i] = (i_head.rpt.keys[i] != '0);
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (r_slots[s] == i_head.rpt.keys[i]) begin
                    ld_prs[i] = 1'b0;
                end
            end
            for (int j = 0; j < i; j++) begin
                if (i_head.rpt.keys[j] == i_head.rpt.keys[i]) begin
                    ld_prs[i] = 1'b0;
                end
            end
        end
    end

    // Pick the lowest pending entry of each mask and the first free slot
    always_comb begin
        mod_idx  = '0;
        rel_idx  = '0;
        prs_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int k = MC - 1; k >= 0; k--) begin
            if (r_mod_mask[k]) begin
                mod_idx = hrk_pkg::MOD_IDX_W'(k);
            end
        end
        for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
            if (r_rel_mask[k]) begin
                rel_idx = SLOT_W'(k);
            end
            if (r_slots[k] == '0) begin
                free_idx = SLOT_W'(k);
                free_any = 1'b1;
            end
        end
        for (int k = UC - 1; k >= 0; k--) begin
            if (r_prs_mask[k]) begin
                prs_idx = hrk_pkg::USAGE_IDX_W'(k);
            end
        end
    end

    assign can_emit = !r_out_valid || o_evt.ready;

    // Sequence one report: modifiers, releases, presses, sync
    always_comb begin
        n_state     = r_state;
        n_slots     = r_slots;
        n_mods      = r_mods;
        n_mod_mask  = r_mod_mask;
        n_rel_mask  = r_rel_mask;
        n_prs_mask  = r_prs_mask;
        n_keys      = r_keys;
        n_any       = r_any;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_kind      = r_kind;
        n_code      = r_code;
        n_pressed   = r_pressed;
        n_last      = r_last;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop      = 1'b1;
                    n_mod_mask = i_head.rpt.mods ^ r_mods;
                    n_mods     = i_head.rpt.mods;
                    n_rel_mask = ld_rel;
                    n_prs_mask = ld_prs;
                    n_keys     = i_head.rpt.keys;
                    n_any      = 1'b0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (can_emit) begin
                    if (r_mod_mask != '0) begin
                        n_mod_mask[mod_idx] = 1'b0;
                        n_out_valid = 1'b1;
                        n_kind      = hrk_pkg::EVT_KEY;
                        n_code      = hrk_pkg::modifier_key(mod_idx);
                        n_pressed   = r_mods[mod_idx];
                        n_last      = 1'b0;
                        n_any       = 1'b1;
                    end else if (r_rel_mask != '0) begin
                        n_rel_mask[rel_idx] = 1'b0;
                        n_slots[rel_idx]    = '0;
                        n_out_valid = 1'b1;
                        n_kind      = hrk_pkg::EVT_KEY;
                        n_code      = r_slots[rel_idx];
                        n_pressed   = 1'b0;
                        n_last      = 1'b0;
                        n_any       = 1'b1;
                    end else if (r_prs_mask != '0) begin
                        // drop the key silently when every slot is taken
                        n_prs_mask[prs_idx] = 1'b0;
                        if (free_any) begin
                            n_slots[free_idx] = r_keys[prs_idx];
                            n_out_valid = 1'b1;
                            n_kind      = hrk_pkg::EVT_KEY;
                            n_code      = r_keys[prs_idx];
                            n_pressed   = 1'b1;
                            n_last      = 1'b0;
                            n_any       = 1'b1;
                        end
                    end else begin
                        if (r_any) begin
                            n_out_valid = 1'b1;
                            n_kind      = hrk_pkg::EVT_SYNC;
                            n_code      = '0;
                            n_pressed   = 1'b0;
                            n_last      = 1'b1;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slots     <= '0;
            r_mods      <= '0;
            r_mod_mask  <= '0;
            r_rel_mask  <= '0;
            r_prs_mask  <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slots     <= n_slots;
            r_mods      <= n_mods;
            r_mod_mask  <= n_mod_mask;
            r_rel_mask  <= n_rel_mask;
            r_prs_mask  <= n_prs_mask;
            r_any       <= n_any;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold report keys and the output word payload
    always_ff @(posedge i_clk) begin
        r_keys    <= n_keys;
        r_kind    <= n_kind;
        r_code    <= n_code;
        r_pressed <= n_pressed;
        r_last    <= n_last;
    end

    assign o_evt.valid      = r_out_valid;
    assign o_evt.event_kind = r_kind;
    assign o_evt.key_code   = r_code;
    assign o_evt.pressed    = r_pressed;
    assign o_evt.last       = r_last;

endmodule

[rtl/hid_report_to_key_events.sv]
// Top level: boot keyboard report words in, key press/release and sync words out.
//
// i_rpt carries one boot report per word: a modifier byte (bits 0..3 used:
// ctrl, shift, alt, meta) and six HID usage bytes. o_evt carries one event
// per word: modifier changes first, then releases of held keys that left
// the report in slot order, then presses of new keys in report order, then
// a sync word with last set. A report that changes nothing gives no words.
// An accepted report is written to the queue, and the back end takes it from
// the queue head when idle; the report then passes through the back end's
// pending masks and its event output register before the first event word
// shows. The back end takes a new report only after it has expanded the last
// one, and its single event output register holds one event word at a time;
// a full report yields 16 key events and a sync. A two-entry report queue
// lets new reports be accepted while earlier ones are being expanded.
// Reset clears all key slots, the modifier state, the queue and the output.
// When the receiver stalls, the output word holds, the sequencer waits and
// the queue fills; i_rpt.ready drops only when the queue is full.
module hid_report_to_key_events #(
    parameter int KEY_SLOTS = hrk_pkg::DEF_KEY_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrk_rpt_if.sink   i_rpt,
    hrk_evt_if.source o_evt
);

    hrk_pkg::t_q_head head;
    logic             pop;

    hrk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rpt   (i_rpt),
        .i_pop   (pop),
        .o_head  (head)
    );

    hrk_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_evt   (o_evt)
    );

endmodule

[rtl/hrk_chk.sv]
// Port-level checks on the event channel, bound to the top level.
module hrk_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input logic                      i_kind,
    input logic [hrk_pkg::KEY_W-1:0] i_code,
    input logic                      i_pressed,
    input logic                      i_last
);

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("event word dropped while stalled");

    // Mark the sync word, and only it, as last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_kind == hrk_pkg::EVT_SYNC)))
        else $error("last flag does not match sync word");

    // Keep sync words free of key data
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == hrk_pkg::EVT_SYNC |-> i_code == '0 && !i_pressed)
        else $error("sync word carries key data");

    // Never emit a key event for the empty code
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == hrk_pkg::EVT_KEY |-> i_code != '0)
        else $error("key event with empty code");

    // Drop output after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("event word valid after reset");

endmodule

bind hid_report_to_key_events hrk_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_evt.valid),
    .i_ready   (o_evt.ready),
    .i_kind    (o_evt.event_kind),
    .i_code    (o_evt.key_code),
    .i_pressed (o_evt.pressed),
    .i_last    (o_evt.last)
);
